// File: design/lirs_pkg.sv
// lirs_pkg: shared types and constants of the linear interpolation resampler
// holds payload structs, sequencer state codes and register indexes
// no dependencies
package lirs_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int RATE_W     = 19;
  localparam int OFFSET_W   = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_RATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_RATE = 2'd1;

  localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } out_item_t;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_FOLD   = 11'b000_0000_0010,
    S_FOLDW  = 11'b000_0000_0100,
    S_FTS    = 11'b000_0000_1000,
    S_FTW    = 11'b000_0001_0000,
    S_LOOP   = 11'b000_0010_0000,
    S_MUL    = 11'b000_0100_0000,
    S_DSTART = 11'b000_1000_0000,
    S_DWAIT  = 11'b001_0000_0000,
    S_EMIT   = 11'b010_0000_0000,
    S_TAIL   = 11'b100_0000_0000
  } state_t;

endpackage

// File: design/lirs_div.sv
// lirs_div: restoring unsigned divider, one quotient bit per cycle
// used for phase folding, rate ratio and interpolation scaling
// depends on nothing but its parameters
module lirs_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] acc_r, acc_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign shifted = {acc_r, q_r[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    acc_nxt  = acc_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      q_nxt   = {q_r[DVD_W-2:0], fits};
      acc_nxt = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      q_nxt    = dividend;
      acc_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = acc_r;

endmodule

// File: design/linear_interp_resampler.sv
// linear_interp_resampler: sample rate converter by linear interpolation
// set-up of an item: a fold division when a lowered rate leaves the phase too large,
// then the rate ratio division; each interpolated result needs a multiply and a division
// in the 43-step shared divider; one item at a time; held tail results go out as slots free up
// reset: synchronous active-low rst_n; rates return to 48000, stream state to zero
// depends on lirs_pkg and lirs_div
module linear_interp_resampler import lirs_pkg::*; #(
  parameter int MAX_RATIO = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [RATE_W-1:0]     cfg_wdata
);

  localparam int RESULT_CAP = 2 * MAX_RATIO;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);
  localparam int CAP_W      = RATE_W + $clog2(MAX_RATIO + 1);
  localparam int DVD_W      = SAMPLE_W + RATE_W;
  localparam int PROD_W     = DVD_W + 1;
  localparam int DIFF_W     = SAMPLE_W + 1;

  state_t state_r, state_nxt;

  logic [RATE_W-1:0]   src_rate_r, src_rate_nxt;
  logic [RATE_W-1:0]   tgt_rate_r, tgt_rate_nxt;

  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                have_prev_r, have_prev_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [RATE_W-1:0]   phase_r, phase_nxt;

  logic [SAMPLE_W-1:0] cur_r, cur_nxt;
  logic                last_r, last_nxt;
  logic [RATE_W-1:0]   f_r, f_nxt;
  logic [RATE_W-1:0]   t_r, t_nxt;
  logic [RATE_W-1:0]   qft_r, qft_nxt;
  logic [RATE_W-1:0]   rft_r, rft_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SAMPLE_W-1:0] val_r, val_nxt;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [RATE_W-1:0]   f_eff, t_raw, t_eff;
  logic [CAP_W-1:0]    cap;

  logic                div_start, div_done;
  logic [DVD_W-1:0]    div_dvd, div_q;
  logic [RATE_W-1:0]   div_r;

  logic                in_acc, slot_free, emit_ok;
  logic [RATE_W:0]     phase_sum;
  logic                phase_wrap;
  logic [RATE_W-1:0]   phase_adv;
  logic [OFFSET_W-1:0] offset_adv;
  logic [CNT_W-1:0]    n_inc;
  logic                adv_cont, interp_last, tail_last;
  logic [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0] diff_ext, phase_ext;
  logic [DIFF_W+1:0]   q_signed, v_sum;

  // zero rate acts as one; upsampling ratio saturates
  assign f_eff = (src_rate_r == '0) ? RATE_W'(1) : src_rate_r;
  assign t_raw = (tgt_rate_r == '0) ? RATE_W'(1) : tgt_rate_r;
  assign cap   = CAP_W'(f_eff) * CAP_W'(MAX_RATIO);
  assign t_eff = (CAP_W'(t_raw) > cap) ? cap[RATE_W-1:0] : t_raw;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit_ok   = (offset_r == '0) && (n_r < CNT_W'(RESULT_CAP));

  // position advance by one output step
  assign phase_sum  = {1'b0, phase_r} + {1'b0, rft_r};
  assign phase_wrap = phase_sum >= {1'b0, t_r};
  assign phase_adv  = phase_wrap ? RATE_W'(phase_sum - {1'b0, t_r}) : phase_sum[RATE_W-1:0];
  assign offset_adv = offset_r + OFFSET_W'(qft_r) + OFFSET_W'(phase_wrap);
  assign n_inc      = n_r + CNT_W'(1);

  // look ahead to tell whether this result closes the transaction group
  assign adv_cont    = (offset_adv == '0) && (n_inc < CNT_W'(RESULT_CAP));
  assign interp_last = last_r && !adv_cont &&
                       !((n_inc < CNT_W'(RESULT_CAP)) && (offset_adv == OFFSET_W'(1)));
  assign tail_last   = !adv_cont;

  assign diff = {cur_r[SAMPLE_W-1], cur_r} - {prev_r[SAMPLE_W-1], prev_r};

  // operands widened to the product width
  assign diff_ext  = $signed({{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff});
  assign phase_ext = $signed({{(PROD_W-RATE_W){1'b0}}, phase_r});

  // floor division of a negative numerator: floor(x/t) = ~(~x / t)
  assign q_signed = prod_r[PROD_W-1] ? ~{1'b0, div_q[DIFF_W:0]} : {1'b0, div_q[DIFF_W:0]};
  assign v_sum    = {{3{prev_r[SAMPLE_W-1]}}, prev_r} + q_signed;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVD_W'(f_r);
    case (state_r)
      S_FOLD: begin
        div_start = (phase_r >= t_r);
        div_dvd   = DVD_W'(phase_r);
      end
      S_FTS: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(f_r);
      end
      S_DSTART: begin
        div_start = 1'b1;
        div_dvd   = prod_r[PROD_W-1] ? ~prod_r[DVD_W-1:0] : prod_r[DVD_W-1:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lirs_div #(
    .DVD_W (DVD_W),
    .DVS_W (RATE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (t_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    src_rate_nxt = src_rate_r;
    tgt_rate_nxt = tgt_rate_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_SOURCE_RATE: src_rate_nxt = cfg_wdata;
        CFG_TARGET_RATE: tgt_rate_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    offset_nxt    = offset_r;
    phase_nxt     = phase_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    f_nxt         = f_r;
    t_nxt         = t_r;
    qft_nxt       = qft_r;
    rft_nxt       = rft_r;
    n_nxt         = n_r;
    prod_nxt      = prod_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_nxt   = in_data.sample_in;
          last_nxt  = in_data.last_in;
          f_nxt     = f_eff;
          t_nxt     = t_eff;
          n_nxt     = '0;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        state_nxt = (phase_r >= t_r) ? S_FOLDW : S_FTS;
      end
      S_FOLDW: begin
        if (div_done) begin
          offset_nxt = offset_r + OFFSET_W'(div_q[RATE_W-1:0]);
          phase_nxt  = div_r;
          state_nxt  = S_FTS;
        end
      end
      S_FTS: begin
        state_nxt = S_FTW;
      end
      S_FTW: begin
        if (div_done) begin
          qft_nxt = div_q[RATE_W-1:0];
          rft_nxt = div_r;
          if (!have_prev_r) begin
            prev_nxt      = cur_r;
            have_prev_nxt = 1'b1;
            state_nxt     = last_r ? S_TAIL : S_IDLE;
          end else begin
            state_nxt = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (emit_ok) begin
          state_nxt = S_MUL;
        end else begin
          if (offset_r != '0) offset_nxt = offset_r - OFFSET_W'(1);
          prev_nxt  = cur_r;
          state_nxt = last_r ? S_TAIL : S_IDLE;
        end
      end
      S_MUL: begin
        prod_nxt  = diff_ext * phase_ext;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          val_nxt   = v_sum[SAMPLE_W-1:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.sample_out = val_r;
          out_data_nxt.last_out = interp_last;
          phase_nxt             = phase_adv;
          offset_nxt            = offset_adv;
          n_nxt                 = n_inc;
          state_nxt             = S_LOOP;
        end
      end
      S_TAIL: begin
        if (emit_ok) begin
          if (slot_free) begin
            out_valid_nxt         = 1'b1;
            out_data_nxt.sample_out = cur_r;
            out_data_nxt.last_out = tail_last;
            phase_nxt             = phase_adv;
            offset_nxt            = offset_adv;
            n_nxt                 = n_inc;
          end
        end else begin
          // end of stream, stream state back to reset values
          prev_nxt      = '0;
          have_prev_nxt = 1'b0;
          offset_nxt    = '0;
          phase_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      src_rate_r  <= RATE_RESET;
      tgt_rate_r  <= RATE_RESET;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      offset_r    <= '0;
      phase_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_rate_r  <= src_rate_nxt;
      tgt_rate_r  <= tgt_rate_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      offset_r    <= offset_nxt;
      phase_r     <= phase_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    last_r     <= last_nxt;
    f_r        <= f_nxt;
    t_r        <= t_nxt;
    qft_r      <= qft_nxt;
    rft_r      <= rft_nxt;
    prod_r     <= prod_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // phase must be folded below the rate before any result is computed
  a_phase_folded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP || state_r == S_MUL) |-> (phase_r < t_r))
    else $error("phase remainder not below rate in result loop");

  // divider results only arrive while the sequencer waits for them
  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_FOLDW || state_r == S_FTW || state_r == S_DWAIT))
    else $error("divider finished outside a wait state");

  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(RESULT_CAP))
    else $error("result count beyond cap");

  // a result ready with a free slot lands in the output register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free) |=> (out_valid_r && state_r == S_LOOP))
    else $error("emitted result not registered");

endmodule

// File: dv/lirs_stream_checker.sv
// lirs_stream_checker: watches the resampler channels, predicts every interpolated sample
// and compares each result transaction with the oldest prediction
// depends on lirs_pkg
module lirs_stream_checker import lirs_pkg::*; #(
  parameter int MAX_RATIO = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [RATE_W-1:0]     cfg_wdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen
);

  localparam int RESULT_CAP = 2 * MAX_RATIO;

  logic [RATE_W-1:0]          src_rate;
  logic [RATE_W-1:0]          dst_rate;
  logic signed [SAMPLE_W-1:0] held_sample;
  bit                         held_valid;
  int unsigned                whole_ofs;
  int unsigned                phase_rem;
  out_item_t                  expected_samples[$];
  int                         err_count = 0;
  int                         seen_count = 0;

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // move the output position on by one output period
  function automatic void step_phase(int unsigned fr, int unsigned tr);
    whole_ofs = whole_ofs + fr / tr;
    phase_rem = phase_rem + fr % tr;
    if (phase_rem >= tr) begin
      phase_rem = phase_rem - tr;
      whole_ofs = whole_ofs + 1;
    end
  endfunction

  function automatic void push_sample(logic signed [SAMPLE_W-1:0] s);
    out_item_t r;
    r.sample_out = s;
    r.last_out   = 1'b0;
    expected_samples.push_back(r);
  endfunction

  function automatic void interpolate_item(in_item_t it);
    int unsigned fr;
    int unsigned tr;
    longint      cur;
    longint      prev;
    longint      num;
    longint      v;
    int          n;
    out_item_t   tail;
    fr = src_rate;
    tr = dst_rate;
    if (fr == 0) fr = 1;
    if (tr == 0) tr = 1;
    if (tr > fr * MAX_RATIO) tr = fr * MAX_RATIO;
    cur = longint'($signed(it.sample_in));
    n = 0;
    // rate lowered since the last transaction: fold the excess remainder
    if (phase_rem >= tr) begin
      whole_ofs = whole_ofs + phase_rem / tr;
      phase_rem = phase_rem % tr;
    end
    if (!held_valid) begin
      held_sample = it.sample_in;
      held_valid  = 1'b1;
    end else begin
      prev = longint'(held_sample);
      while (whole_ofs == 0 && n < RESULT_CAP) begin
        num = (cur - prev) * longint'(phase_rem);
        v   = prev + floor_div(num, longint'(tr));
        push_sample(v[SAMPLE_W-1:0]);
        n++;
        step_phase(fr, tr);
      end
      if (whole_ofs > 0) whole_ofs = whole_ofs - 1;
      held_sample = it.sample_in;
    end
    if (it.last_in) begin
      // positions past the final sample repeat it
      while (whole_ofs == 0 && n < RESULT_CAP) begin
        push_sample(it.sample_in);
        n++;
        step_phase(fr, tr);
      end
      if (n > 0) begin
        tail = expected_samples.pop_back();
        tail.last_out = 1'b1;
        expected_samples.push_back(tail);
      end
      held_sample = '0;
      held_valid  = 1'b0;
      whole_ofs   = 0;
      phase_rem   = 0;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      src_rate    = RATE_RESET;
      dst_rate    = RATE_RESET;
      held_sample = '0;
      held_valid  = 1'b0;
      whole_ofs   = 0;
      phase_rem   = 0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen_count++;
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample_out %0d last_out %0d",
                 $signed(out_data.sample_out), out_data.last_out);
          err_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_data.sample_out));
            err_count++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out: expected %0d, got %0d", want.last_out, out_data.last_out);
            err_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SOURCE_RATE: src_rate = cfg_wdata;
          CFG_TARGET_RATE: dst_rate = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) interpolate_item(in_data);
    end
    mismatches   <= err_count;
    outstanding  <= expected_samples.size();
    results_seen <= seen_count;
  end

endmodule

// File: dv/tb_linear_interp_resampler.sv
// tb_linear_interp_resampler: stimulus and verdict for the linear interpolation resampler
// drives sample streams and rate settings, checking is done by lirs_stream_checker
// depends on lirs_pkg, linear_interp_resampler and lirs_stream_checker
module tb_linear_interp_resampler;
  import lirs_pkg::*;

  localparam int MAX_RATIO     = 16;
  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 155;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_SOURCE_RATE;
  logic [RATE_W-1:0]     cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int results_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_sent = 0;
  int streams_sent = 0;
  int rate_settings = 0;
  logic signed [SAMPLE_W-1:0] last_sample = '0;

  always #6 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  linear_interp_resampler #(
    .MAX_RATIO(MAX_RATIO)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  lirs_stream_checker #(
    .MAX_RATIO(MAX_RATIO)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
    in_item_t item;
    item.sample_in = s;
    item.last_in   = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    last_sample = s;
  endtask

  // hold the sender off until every predicted result is out and the block settles
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rates(int unsigned src, int unsigned dst);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SOURCE_RATE;
    cfg_wdata <= RATE_W'(src);
    @(posedge clk);
    cfg_addr  <= CFG_TARGET_RATE;
    cfg_wdata <= RATE_W'(dst);
    @(posedge clk);
    cfg_we    <= 1'b0;
    rate_settings++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    logic signed [SAMPLE_W-1:0] delta;
    logic [31:0]                raw;
    raw = $urandom();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: begin
        // small steps keep the interpolated slope shallow
        delta = $signed(SAMPLE_W'($urandom_range(511))) - 24'sd256;
        return last_sample + delta;
      end
      4: return raw[0] ? -24'sd1 : 24'sd0;
      default: return raw[SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic random_rates();
    int unsigned src;
    int unsigned dst;
    int unsigned hi;
    case ($urandom_range(7))
      0: begin src = 44100; dst = 48000; end
      1: begin src = 48000; dst = 44100; end
      // tiny rates, zero and over-ratio targets included
      2: begin src = $urandom_range(16); dst = $urandom_range(40); end
      3: begin src = 8000; dst = $urandom_range(128000, 8000); end
      4: begin src = 96000; dst = 44100; end
      5: begin src = $urandom_range(384000, 1); dst = src; end
      6: begin
        src = $urandom_range(384000, 1000);
        dst = src * $urandom_range(16, 2) / $urandom_range(2, 1);
        if (dst > 384000) dst = 384000;
      end
      default: begin
        src = $urandom_range(384000, 1);
        hi  = (src * 16 > 384000) ? 384000 : src * 16;
        dst = $urandom_range(hi, src / 4 + 1);
      end
    endcase
    set_rates(src, dst);
  endtask

  task automatic random_stream();
    int len;
    int split;
    if ($urandom_range(1) == 1) begin
      wait_for_quiet();
      random_rates();
    end
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
    split = len;
    // sometimes retune between transactions of one stream
    if (len > 1 && $urandom_range(5) == 0) split = $urandom_range(len - 1, 1);
    for (int i = 0; i < len; i++) begin
      if (i == split) begin
        wait_for_quiet();
        random_rates();
      end
      send_sample(next_sample(), i == len - 1);
    end
    streams_sent++;
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("tb: no transaction for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 81;

    // reset rates, full-scale steps
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(-24'sd1, 1'b1);
    streams_sent++;

    // zero rates behave as one
    wait_for_quiet();
    set_rates(0, 0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    streams_sent++;

    // target far above the ratio cap, most results per transaction
    wait_for_quiet();
    set_rates(1000, 524287);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    streams_sent++;

    // lower the target mid-stream so the remainder has to fold
    wait_for_quiet();
    set_rates(3, 7);
    send_sample(next_sample(), 1'b0);
    send_sample(next_sample(), 1'b0);
    wait_for_quiet();
    set_rates(3, 1);
    send_sample(next_sample(), 1'b0);
    send_sample(next_sample(), 1'b1);
    streams_sent++;

    // deep downsampling, final transaction emits nothing
    wait_for_quiet();
    set_rates(384000, 1);
    send_sample(next_sample(), 1'b0);
    send_sample(next_sample(), 1'b0);
    send_sample(next_sample(), 1'b1);
    streams_sent++;

    // top rates, a one-sample stream then a short one
    wait_for_quiet();
    set_rates(384000, 384000);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(24'sd1, 1'b1);
    streams_sent += 2;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 26; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) random_stream();
    end

    wait_for_quiet();
    $display("tb: %0d samples in %0d streams, %0d results checked",
             samples_sent, streams_sent, results_seen);
    $display("tb: %0d rate settings, stalls swept on both sides and then none",
             rate_settings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
